>>> hw/rtl/chord_keyboard_entry_defines.svh
// Assertion macros for the chord keyboard entry block.
// Used by the top level only; needs a signal named clock and one named reset in scope.
`ifndef CHORD_KEYBOARD_ENTRY_DEFINES_SVH
`define CHORD_KEYBOARD_ENTRY_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CKE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chord keyboard entry: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CKE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chord keyboard entry: next-cycle check failed");

`endif

>>> hw/rtl/cke_pkg.sv
// Package for the chord keyboard entry block: payload structs, codes and the chord table.
// Used by every module of the block; depends on nothing.
package cke_pkg;

   localparam int RING_DEPTH_DEFAULT = 16;

   localparam logic [9:0] THRESHOLD_RESET = 10'd260;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KB_MODE   = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;

   // Item kinds.
   localparam logic [1:0] ITEM_BUTTON = 2'd0;
   localparam logic [1:0] ITEM_TOUCH  = 2'd1;
   localparam logic [1:0] ITEM_POP    = 2'd2;

   // Buttons above the color buttons.
   localparam logic [2:0] BTN_LAST_COLOUR = 3'd4;
   localparam logic [2:0] BTN_CTRL        = 3'd5;
   localparam logic [2:0] BTN_AI          = 3'd6;

   // Pages.
   localparam logic [2:0] PG_UPPER   = 3'd0;
   localparam logic [2:0] PG_LOWER   = 3'd1;
   localparam logic [2:0] PG_NUMBERS = 3'd2;
   localparam logic [2:0] PG_SYMBOLS = 3'd3;
   localparam logic [2:0] PG_HEX     = 3'd4;

   // Keyboard modes.
   localparam logic [2:0] KB_ALL       = 3'd0;
   localparam logic [2:0] KB_LOWER_NUM = 3'd1;
   localparam logic [2:0] KB_UPPER_SYM = 3'd2;
   localparam logic [2:0] KB_NUM_ONLY  = 3'd3;
   localparam logic [2:0] KB_HEX_ONLY  = 3'd4;

   localparam logic       KIND_CHAR      = 1'b0;
   localparam logic       KIND_BACKSPACE = 1'b1;
   localparam logic [6:0] CHAR_SPACE     = 7'h20;
   localparam logic [6:0] CHAR_NONE      = 7'h00;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] button;
      logic [9:0] touch_y;
   } req_payload_type;

   typedef struct packed {
      logic       event_valid;
      logic       event_kind;
      logic [6:0] event_char;
      logic       in_chord;
      logic [2:0] current_page;
      logic [4:0] queued;
   } rsp_payload_type;

   typedef struct packed {
      logic       write;
      logic [1:0] index;
      logic [9:0] data;
   } csr_write_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       kind;
      logic [6:0] ch;
   } ring_cmd_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] ch;
   } ring_entry_type;

   typedef struct packed {
      logic       in_chord;
      logic [2:0] page;
   } ctrl_status_type;

   function automatic logic [2:0] first_page(input logic [2:0] kb_mode);
      logic [2:0] pg;
      unique case (kb_mode)
         KB_UPPER_SYM: pg = PG_UPPER;
         KB_NUM_ONLY:  pg = PG_NUMBERS;
         KB_HEX_ONLY:  pg = PG_HEX;
         default:      pg = PG_LOWER;
      endcase
      return pg;
   endfunction

   function automatic logic [2:0] next_page(input logic [2:0] kb_mode, input logic [2:0] pg);
      logic [2:0] nxt;
      unique case (kb_mode)
         KB_LOWER_NUM: nxt = (pg == PG_LOWER) ? PG_NUMBERS : PG_LOWER;
         KB_UPPER_SYM: nxt = (pg == PG_UPPER) ? PG_SYMBOLS : PG_UPPER;
         KB_NUM_ONLY:  nxt = PG_NUMBERS;
         KB_HEX_ONLY:  nxt = PG_HEX;
         default: begin
            // The full cycle runs upper, lower, numbers and back to upper.
            nxt = (pg == PG_UPPER || pg == PG_LOWER) ? pg + 3'd1 : PG_UPPER;
         end
      endcase
      return nxt;
   endfunction

   // Character for a page, group and second color button; zero marks an empty slot.
   function automatic logic [6:0] chord_char(input logic [2:0] pg, input logic [2:0] grp,
                                             input logic [2:0] btn);
      logic [39:0] row;
      logic [6:0]  ch;
      unique case ({pg, grp})
         {PG_UPPER, 3'd0}:   row = "ABCDE";
         {PG_UPPER, 3'd1}:   row = "FGHIJ";
         {PG_UPPER, 3'd2}:   row = "KLMNO";
         {PG_UPPER, 3'd3}:   row = "PQRST";
         {PG_UPPER, 3'd4}:   row = "UVWXY";
         {PG_LOWER, 3'd0}:   row = "abcde";
         {PG_LOWER, 3'd1}:   row = "fghij";
         {PG_LOWER, 3'd2}:   row = "klmno";
         {PG_LOWER, 3'd3}:   row = "pqrst";
         {PG_LOWER, 3'd4}:   row = "uvwxy";
         {PG_NUMBERS, 3'd0}: row = "01234";
         {PG_NUMBERS, 3'd1}: row = "56789";
         {PG_NUMBERS, 3'd2}: row = "+^.<>";
         {PG_NUMBERS, 3'd3}: row = "=*/~-";
         {PG_NUMBERS, 3'd4}: row = "()[]z";
         {PG_SYMBOLS, 3'd0}: row = "!@#$%";
         {PG_SYMBOLS, 3'd1}: row = "^&_`~";
         {PG_SYMBOLS, 3'd2}: row = "{}\\|;";
         {PG_SYMBOLS, 3'd3}: row = "\"',=?";
         {PG_SYMBOLS, 3'd4}: row = {"/z", 24'h0};
         {PG_HEX, 3'd0}:     row = "01234";
         {PG_HEX, 3'd1}:     row = "56789";
         {PG_HEX, 3'd2}:     row = "ABCDE";
         {PG_HEX, 3'd3}:     row = {"F", 32'h0};
         default:            row = 40'h0;
      endcase
      unique case (btn)
         3'd0:    ch = row[38:32];
         3'd1:    ch = row[30:24];
         3'd2:    ch = row[22:16];
         3'd3:    ch = row[14:8];
         3'd4:    ch = row[6:0];
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/cke_ctrl.sv
// Chord, page and configuration state of the chord keyboard entry block.
// Depends on cke_pkg; drives the push and pop commands for cke_ring.
module cke_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  cke_pkg::req_payload_type item,
   input  cke_pkg::csr_write_type   csr,
   output cke_pkg::ring_cmd_type    ring_cmd,
   output cke_pkg::ctrl_status_type status
);
   import cke_pkg::*;

   logic [2:0] kb_mode_ff, kb_mode_in;
   logic [9:0] threshold_ff, threshold_in;
   logic [2:0] page_ff, page_in;
   logic [2:0] group_ff, group_in;
   logic       awaiting_ff, awaiting_in;
   logic [6:0] chord_ch;

   assign chord_ch = chord_char(page_ff, group_ff, item.button);

   always_comb begin
      kb_mode_in   = kb_mode_ff;
      threshold_in = threshold_ff;
      page_in      = page_ff;
      group_in     = group_ff;
      awaiting_in  = awaiting_ff;
      ring_cmd     = '{push: 1'b0, pop: 1'b0, kind: KIND_CHAR, ch: CHAR_NONE};
      if (accept) begin
         unique case (item.mode)
            ITEM_BUTTON: begin
               priority if (item.button <= BTN_LAST_COLOUR) begin
                  if (!awaiting_ff) begin
                     group_in    = item.button;
                     awaiting_in = 1'b1;
                  end else begin
                     awaiting_in = 1'b0;
                     // An empty slot ends the chord without a character.
                     ring_cmd.push = (chord_ch != CHAR_NONE);
                     ring_cmd.ch   = chord_ch;
                  end
               end else if (item.button == BTN_CTRL || item.button == BTN_AI) begin
                  if (!awaiting_ff) begin
                     page_in = next_page(kb_mode_ff, page_ff);
                  end else begin
                     awaiting_in = 1'b0;
                  end
               end else begin
                  awaiting_in = awaiting_ff;
               end
            end
            ITEM_TOUCH: begin
               ring_cmd.push = 1'b1;
               if (item.touch_y > threshold_ff) begin
                  ring_cmd.ch = CHAR_SPACE;
               end else begin
                  ring_cmd.kind = KIND_BACKSPACE;
               end
            end
            ITEM_POP: begin
               ring_cmd.pop = 1'b1;
            end
            default: begin
               ring_cmd.pop = 1'b0;
            end
         endcase
      end
      if (csr.write) begin
         unique case (csr.index)
            CSR_KB_MODE: begin
               kb_mode_in  = (csr.data[2:0] > KB_HEX_ONLY) ? KB_ALL : csr.data[2:0];
               page_in     = first_page(kb_mode_in);
               awaiting_in = 1'b0;
            end
            CSR_THRESHOLD: begin
               threshold_in = csr.data;
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_mode_ff   <= KB_ALL;
         threshold_ff <= THRESHOLD_RESET;
         page_ff      <= PG_LOWER;
         group_ff     <= 3'd0;
         awaiting_ff  <= 1'b0;
      end else begin
         kb_mode_ff   <= kb_mode_in;
         threshold_ff <= threshold_in;
         page_ff      <= page_in;
         group_ff     <= group_in;
         awaiting_ff  <= awaiting_in;
      end
   end

   assign status = '{in_chord: awaiting_in, page: page_in};

endmodule

>>> hw/rtl/cke_ring.sv
// Event ring of the chord keyboard entry block: memory, head pointer and fill count.
// Depends on cke_pkg; takes push and pop commands from cke_ctrl.
module cke_ring #(
   parameter int RING_DEPTH = cke_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cke_pkg::ring_cmd_type   cmd,
   output cke_pkg::ring_entry_type rd_entry,
   output logic                    pop_hit,
   output logic [4:0]              queued_next
);
   import cke_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   ring_entry_type mem [RING_DEPTH];
   ring_entry_type rd_entry_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_inc;
   logic [PTR_W:0]   tail_sum;
   logic [PTR_W-1:0] tail;
   logic             full;

   assign full     = (count_ff == CNT_W'(RING_DEPTH));
   assign head_inc = (head_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_sum = (PTR_W+1)'(head_ff) + (PTR_W+1)'(count_ff);

   // When full, the new event takes the oldest slot and the head moves past it.
   always_comb begin
      if (full) begin
         tail = head_ff;
      end else if (tail_sum >= (PTR_W+1)'(RING_DEPTH)) begin
         tail = PTR_W'(tail_sum - (PTR_W+1)'(RING_DEPTH));
      end else begin
         tail = PTR_W'(tail_sum);
      end
   end

   assign pop_hit = cmd.pop && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.push) begin
         if (full) begin
            head_in = head_inc;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (pop_hit) begin
         head_in  = head_inc;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail] <= '{kind: cmd.kind, ch: cmd.ch};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_entry_ff <= mem[head_ff];
      end
   end

   assign rd_entry    = rd_entry_ff;
   assign queued_next = 5'(count_in);

endmodule

>>> hw/rtl/chord_keyboard_entry.sv
// Chord keyboard entry block: top level with the result stage and an output register.
// An accepted request moves through the first stage and then the output register to its result;
// one request per cycle sustained while rsp_stall does not hold the output. Synchronous reset clears
// the chord, page, mode, threshold and ring pointers; the ring memory itself is not cleared.
// Depends on cke_pkg, cke_ctrl, cke_ring and chord_keyboard_entry_defines.svh.
`include "chord_keyboard_entry_defines.svh"

module chord_keyboard_entry #(
   parameter int RING_DEPTH = cke_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cke_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cke_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [9:0]               csr_data
);
   import cke_pkg::*;

   logic            accept;
   logic            advance;
   csr_write_type   csr;
   ring_cmd_type    ring_cmd;
   ctrl_status_type status;
   ring_entry_type  rd_entry;
   logic            pop_hit;
   logic [4:0]      queued_next;

   logic            s1_valid_ff, s1_valid_in;
   logic            s1_hit_ff;
   ctrl_status_type s1_status_ff;
   logic [4:0]      s1_queued_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   assign csr_ready = 1'b1;
   assign csr       = '{write: csr_valid && csr_ready, index: csr_index, data: csr_data};

   // The first stage moves on when the output register is empty or being taken.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   cke_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_payload),
      .csr      (csr),
      .ring_cmd (ring_cmd),
      .status   (status)
   );

   cke_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ring_cmd),
      .rd_entry    (rd_entry),
      .pop_hit     (pop_hit),
      .queued_next (queued_next)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff    <= pop_hit;
         s1_status_ff <= status;
         s1_queued_ff <= queued_next;
      end
   end

   // The ring read data is only valid for a pop that found an event.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.event_valid  <= s1_hit_ff;
         rsp_ff.event_kind   <= s1_hit_ff & rd_entry.kind;
         rsp_ff.event_char   <= s1_hit_ff ? rd_entry.ch : CHAR_NONE;
         rsp_ff.in_chord     <= s1_status_ff.in_chord;
         rsp_ff.current_page <= s1_status_ff.page;
         rsp_ff.queued       <= s1_queued_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CKE_ASSERT_SAME(a_no_event_fields_zero,
      rsp_valid && !rsp_payload.event_valid,
      rsp_payload.event_kind == 1'b0 && rsp_payload.event_char == CHAR_NONE)

   `CKE_ASSERT_SAME(a_page_in_range,
      rsp_valid, rsp_payload.current_page <= PG_HEX)

   `CKE_ASSERT_NEXT(a_held_stage_stays,
      s1_valid_ff && !advance, s1_valid_ff && $stable(s1_queued_ff))

endmodule
